// ===== sv/egcd_pkg.sv =====
`default_nettype none

package egcd_pkg;

  // Default operand width and the fixed width of the division counter.
  localparam int DEF_WIDTH = 32;
  localparam int CNT_W     = 7;

  // Operand source of the shared divider.
  typedef enum logic [1:0] {
    DS_AB,
    DS_XY,
    DS_LCM
  } div_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_e div_src;
    logic     first_upd;
    logic     step_q;
    logic     step_upd;
    logic     fin;
    logic     res_write;
  } egcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic b_zero;
    logic y_zero;
    logic div_busy;
    logic mul_busy;
  } egcd_stat_t;

endpackage

`default_nettype wire

// ===== sv/egcd_in_if.sv =====
`default_nettype none

interface egcd_in_if import egcd_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] operand_a;
  logic signed [WIDTH-1:0] operand_b;

  modport source (output valid, operand_a, operand_b, input ready);
  modport sink   (input valid, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

// ===== sv/egcd_out_if.sv =====
`default_nettype none

interface egcd_out_if import egcd_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) ();
  logic                    valid;
  logic                    ready;
  logic        [WIDTH-1:0] gcd_value;
  logic signed [WIDTH:0]   coef_r;
  logic signed [WIDTH:0]   coef_s;
  logic [2*WIDTH-2:0]      lcm_value;
  logic [CNT_W-1:0]        division_count;
  logic                    zero_divisor;

  modport source (output valid, gcd_value, coef_r, coef_s, lcm_value, division_count,
                  zero_divisor, input ready);
  modport sink   (input valid, gcd_value, coef_r, coef_s, lcm_value, division_count,
                  zero_divisor, output ready);
endinterface

`default_nettype wire

// ===== sv/egcd_ctrl.sv =====
`default_nettype none

module egcd_ctrl import egcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  input  wire egcd_stat_t stat_i,
  output egcd_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_DIV0,
    S_TEST,
    S_DIVS,
    S_CMUL,
    S_LMUL,
    S_LDIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.div_src = DS_AB;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.b_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DS_AB;
          state_d         = S_DIV0;
        end
      end
      S_DIV0: begin
        if (!stat_i.div_busy) begin
          cmd_o.first_upd = 1'b1;
          state_d         = S_TEST;
        end
      end
      S_TEST: begin
        if (stat_i.y_zero) begin
          cmd_o.fin = 1'b1;
          state_d   = S_LMUL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DS_XY;
          state_d         = S_DIVS;
        end
      end
      S_DIVS: begin
        if (!stat_i.div_busy) begin
          cmd_o.step_q = 1'b1;
          state_d      = S_CMUL;
        end
      end
      S_CMUL: begin
        if (!stat_i.mul_busy) begin
          cmd_o.step_upd = 1'b1;
          state_d        = S_TEST;
        end
      end
      S_LMUL: begin
        if (!stat_i.mul_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DS_LCM;
          state_d         = S_LDIV;
        end
      end
      S_LDIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_write = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/egcd_dp.sv =====
`default_nettype none

module egcd_dp import egcd_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire egcd_cmd_t               cmd_i,
  output egcd_stat_t                   stat_o,
  input  wire logic signed [WIDTH-1:0] operand_a_i,
  input  wire logic signed [WIDTH-1:0] operand_b_i,
  output logic        [WIDTH-1:0]      gcd_value_o,
  output logic signed [WIDTH:0]        coef_r_o,
  output logic signed [WIDTH:0]        coef_s_o,
  output logic [2*WIDTH-2:0]           lcm_value_o,
  output logic [CNT_W-1:0]             division_count_o,
  output logic                         zero_divisor_o
);

  localparam int W    = WIDTH;
  localparam int CW   = WIDTH + 1;
  localparam int DW   = 2 * WIDTH;
  localparam int LW   = 2 * WIDTH - 1;
  localparam int DCW  = $clog2(DW);
  localparam int MCW  = $clog2(CW);

  function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
    abs_w = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // Algorithm state
  logic signed [W-1:0] a_q, b_q, x_q, y_q;
  logic [W-1:0]        m_q, g_q;
  logic [CW-1:0]       rp_q, sp_q, rc_q, sc_q;
  logic [CNT_W-1:0]    cnt_q;

  // Shared restoring divider
  logic [DW-1:0]  dd_q;
  logic [W-1:0]   dv_q;
  logic [W:0]     dr_q;
  logic [DCW-1:0] dcnt_q;
  logic           dbusy_q;

  // Shared shift-and-add multiplier with two accumulators
  logic [CW-1:0]  mpl_q;
  logic [DW-1:0]  mc0_q, mc1_q, acc0_q, acc1_q;
  logic [MCW-1:0] mcnt_q;
  logic           mbusy_q;

  // Result register
  logic [W-1:0]     res_g_q;
  logic [CW-1:0]    res_r_q, res_s_q;
  logic [LW-1:0]    res_l_q;
  logic [CNT_W-1:0] res_c_q;
  logic             res_z_q;

  // Euclidean quotient and remainder from the unsigned divider result
  logic [W-1:0]  ex, ey, qu, ru;
  logic [CW-1:0] qu_e, qt, qf;
  logic [W-1:0]  mf;
  logic          adj;

  always_comb begin
    ex   = cmd_i.first_upd ? a_q : x_q;
    ey   = cmd_i.first_upd ? b_q : y_q;
    qu   = dd_q[W-1:0];
    ru   = dr_q[W-1:0];
    qu_e = {1'b0, qu};
    qt   = (ex[W-1] ^ ey[W-1]) ? (~qu_e + CW'(1)) : qu_e;
    adj  = ex[W-1] && (ru != '0);
    if (adj) begin
      qf = ey[W-1] ? (qt + CW'(1)) : (qt - CW'(1));
      mf = abs_w(ey) - ru;
    end else begin
      qf = qt;
      mf = ru;
    end
  end

  // One divider step: shift in the next dividend bit, subtract when it fits.
  logic [W:0] rs;
  logic       ge;
  always_comb begin
    rs = {dr_q[W-1:0], dd_q[DW-1]};
    ge = (rs >= {1'b0, dv_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      mbusy_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
      end else if (dbusy_q && dcnt_q == '0) begin
        dbusy_q <= 1'b0;
      end
      if (cmd_i.step_q || cmd_i.fin) begin
        mbusy_q <= 1'b1;
      end else if (mbusy_q && mcnt_q == '0) begin
        mbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= operand_a_i;
      b_q   <= operand_b_i;
      cnt_q <= '0;
    end
    if (cmd_i.first_upd) begin
      rp_q  <= '0;
      sp_q  <= CW'(1);
      rc_q  <= CW'(1);
      sc_q  <= ~qf + CW'(1);
      x_q   <= b_q;
      y_q   <= mf;
      cnt_q <= CNT_W'(1);
    end
    if (cmd_i.step_q) begin
      m_q <= mf;
    end
    if (cmd_i.step_upd) begin
      rp_q  <= rc_q;
      sp_q  <= sc_q;
      rc_q  <= rp_q - acc0_q[CW-1:0];
      sc_q  <= sp_q - acc1_q[CW-1:0];
      x_q   <= y_q;
      y_q   <= m_q;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.fin) begin
      if (x_q[W-1]) begin
        g_q  <= ~x_q + W'(1);
        rp_q <= ~rp_q + CW'(1);
        sp_q <= ~sp_q + CW'(1);
      end else begin
        g_q <= x_q;
      end
    end

    // Divider
    if (cmd_i.div_start) begin
      dr_q   <= '0;
      dcnt_q <= DCW'(DW - 1);
      unique case (cmd_i.div_src)
        DS_AB: begin
          dd_q <= {{W{1'b0}}, abs_w(a_q)};
          dv_q <= abs_w(b_q);
        end
        DS_XY: begin
          dd_q <= {{W{1'b0}}, abs_w(x_q)};
          dv_q <= abs_w(y_q);
        end
        DS_LCM: begin
          dd_q <= acc0_q;
          dv_q <= g_q;
        end
        default: begin
          dd_q <= '0;
          dv_q <= g_q;
        end
      endcase
    end else if (dbusy_q) begin
      dr_q   <= ge ? (rs - {1'b0, dv_q}) : rs;
      dd_q   <= {dd_q[DW-2:0], ge};
      dcnt_q <= dcnt_q - DCW'(1);
    end

    // Multiplier
    if (cmd_i.step_q) begin
      mpl_q  <= qf;
      mc0_q  <= DW'(rc_q);
      mc1_q  <= DW'(sc_q);
      acc0_q <= '0;
      acc1_q <= '0;
      mcnt_q <= MCW'(CW - 1);
    end else if (cmd_i.fin) begin
      mpl_q  <= {1'b0, abs_w(a_q)};
      mc0_q  <= DW'(abs_w(b_q));
      mc1_q  <= '0;
      acc0_q <= '0;
      acc1_q <= '0;
      mcnt_q <= MCW'(CW - 1);
    end else if (mbusy_q) begin
      if (mpl_q[0]) begin
        acc0_q <= acc0_q + mc0_q;
        acc1_q <= acc1_q + mc1_q;
      end
      mc0_q  <= {mc0_q[DW-2:0], 1'b0};
      mc1_q  <= {mc1_q[DW-2:0], 1'b0};
      mpl_q  <= {1'b0, mpl_q[CW-1:1]};
      mcnt_q <= mcnt_q - MCW'(1);
    end

    if (cmd_i.res_write) begin
      res_z_q <= (b_q == '0);
      if (b_q == '0) begin
        res_g_q <= '0;
        res_r_q <= '0;
        res_s_q <= '0;
        res_l_q <= '0;
        res_c_q <= '0;
      end else begin
        res_g_q <= g_q;
        res_r_q <= rp_q;
        res_s_q <= sp_q;
        res_l_q <= dd_q[LW-1:0];
        res_c_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    stat_o.b_zero   = (b_q == '0);
    stat_o.y_zero   = (y_q == '0);
    stat_o.div_busy = dbusy_q;
    stat_o.mul_busy = mbusy_q;
  end

  assign gcd_value_o      = res_g_q;
  assign coef_r_o         = res_r_q;
  assign coef_s_o         = res_s_q;
  assign lcm_value_o      = res_l_q;
  assign division_count_o = res_c_q;
  assign zero_divisor_o   = res_z_q;

endmodule

`default_nettype wire

// ===== sv/extended_gcd_lcm.sv =====
// Channel  Direction  Payload
// in_i     sink       operand_a, operand_b (signed)
// out_o    source     gcd_value, coef_r, coef_s, lcm_value, division_count, zero_divisor
//
// One item is in flight at a time. Each Euclid step after the first division runs a
// test, a division in the shared restoring divider and a multiplication in the
// shift-and-add multiplier. When operand_b is zero the block skips the arithmetic
// and writes a result with zero_divisor set. Reset is asynchronous and active low.
// The output register holds a finished item while the sink stalls, and the next
// item is accepted as soon as the result has been written there.

`default_nettype none

module extended_gcd_lcm import egcd_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  egcd_in_if.sink     in_i,
  egcd_out_if.source  out_o
);

  // Command and status between the sequencer and the arithmetic.
  egcd_cmd_t  cmd;
  egcd_stat_t stat;

  // The controller steps through the first division, the Euclid loop,
  // the sign repair and the lcm, and owns both handshakes.
  egcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the operands, the remainder pair, the Bezout
  // coefficients (kept modulo 2^(WIDTH+1)), the shared divider and
  // multiplier, and the result register.
  egcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operand_a_i      (in_i.operand_a),
    .operand_b_i      (in_i.operand_b),
    .gcd_value_o      (out_o.gcd_value),
    .coef_r_o         (out_o.coef_r),
    .coef_s_o         (out_o.coef_s),
    .lcm_value_o      (out_o.lcm_value),
    .division_count_o (out_o.division_count),
    .zero_divisor_o   (out_o.zero_divisor)
  );

`ifndef SYNTHESIS
  // After an item is taken the block is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while still busy");

  // A zero divisor result carries all-zero fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.zero_divisor) |->
      (out_o.gcd_value == '0 && out_o.division_count == '0))
    else $error("zero divisor result has nonzero fields");

  // A normal result has a nonzero gcd and counts at least two divisions.
  a_normal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.zero_divisor) |->
      (out_o.gcd_value != '0 && out_o.division_count >= CNT_W'(2)))
    else $error("normal result is malformed");

  // The divider and the multiplier never run at the same time.
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.div_busy && stat.mul_busy))
    else $error("divider and multiplier busy together");
`endif

endmodule

`default_nettype wire
